// ----- rtl/crcp_pkg.sv -----
package crcp_pkg;

  // field widths fixed by the record format
  localparam int POS_W    = 17;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int CHAR_W   = 16;
  localparam int NULS_W   = 15;
  localparam int KIND_W   = 2;
  localparam int MAX_RES  = 3;
  localparam int CNT_W    = 2;

  localparam int HDR_BYTES         = 12;
  localparam int BUFFER_BYTES_DEF  = 64 * 1024;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR      = 2'd0,
    KIND_REC_END   = 2'd1,
    KIND_OK        = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   character;
    logic [NULS_W-1:0]   nuls_before;
    logic [WORD_W-1:0]   action;
  } result_t;

  // all results caused by one byte
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic    [CNT_W-1:0]   cnt;
  } batch_t;

endpackage

// ----- rtl/crcp_in_if.sv -----
interface crcp_in_if;
  logic                             valid;
  logic                             ready;
  logic [crcp_pkg::BYTE_W-1:0]      byte_value;
  logic [crcp_pkg::POS_W-1:0]       batch_length;
  logic                             last;

  modport source (output valid, byte_value, batch_length, last, input ready);
  modport sink   (input valid, byte_value, batch_length, last, output ready);
endinterface

// ----- rtl/crcp_out_if.sv -----
interface crcp_out_if;
  logic                             valid;
  logic                             ready;
  logic [crcp_pkg::KIND_W-1:0]      kind;
  logic [crcp_pkg::CHAR_W-1:0]      character;
  logic [crcp_pkg::NULS_W-1:0]      nuls_before;
  logic [crcp_pkg::WORD_W-1:0]      action;
  logic                             run_end;

  modport source (output valid, kind, character, nuls_before, action, run_end, input ready);
  modport sink   (input valid, kind, character, nuls_before, action, run_end, output ready);
endinterface

// ----- rtl/crcp_parse.sv -----
module crcp_parse #(
  parameter int BUFFER_BYTES = crcp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [crcp_pkg::BYTE_W-1:0]  in_byte,
  input  logic [crcp_pkg::POS_W-1:0]   in_blen,
  input  logic                         in_last,
  input  logic                         buf_free,
  output logic                         buf_load,
  output crcp_pkg::batch_t             buf_batch
);

  localparam logic [crcp_pkg::POS_W-1:0] BUF_MAX = crcp_pkg::POS_W'(BUFFER_BYTES);
  localparam int W = crcp_pkg::WORD_W;
  localparam int P = crcp_pkg::POS_W;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // input register
  logic                         ivld_r;
  logic [crcp_pkg::BYTE_W-1:0]  ibyte_r;
  logic [P-1:0]                 iblen_r;
  logic                         ilast_r;

  // parse state
  logic [P-1:0]                 pos_r, pos_nxt;
  logic [P-1:0]                 vt_r, vt_nxt;
  logic [P-1:0]                 rs_r, rs_nxt;
  logic [W-1:0]                 nxt_off_r, nxt_off_nxt;
  logic [W-1:0]                 act_r, act_nxt;
  logic [W-1:0]                 nlen_r, nlen_nxt;
  logic [crcp_pkg::BYTE_W-1:0]  lo_r, lo_nxt;
  logic [crcp_pkg::NULS_W-1:0]  nuls_r, nuls_nxt;
  logic                         nne_r, nne_nxt;
  phase_t                       ph_r, ph_nxt;

  logic                         consume;
  crcp_pkg::batch_t             batch;

  function automatic crcp_pkg::batch_t push(crcp_pkg::batch_t b, crcp_pkg::kind_t k,
                                            logic [crcp_pkg::CHAR_W-1:0] ch,
                                            logic [crcp_pkg::NULS_W-1:0] nc,
                                            logic [W-1:0] ac);
    crcp_pkg::batch_t r;
    r = b;
    if (r.cnt < crcp_pkg::CNT_W'(crcp_pkg::MAX_RES)) begin
      r.res[r.cnt].kind        = k;
      r.res[r.cnt].character   = ch;
      r.res[r.cnt].nuls_before = nc;
      r.res[r.cnt].action      = ac;
      r.cnt                    = r.cnt + 1'b1;
    end
    return r;
  endfunction

  assign consume   = ivld_r & buf_free;
  assign in_ready  = ~ivld_r | consume;
  assign buf_load  = consume;
  assign buf_batch = batch;

  // per-byte parse step
  always_comb begin
    logic [3:0]                   k;
    logic [P-1:0]                 koff;
    logic [4:0]                   sh;
    logic [P:0]                   name_start;
    logic [P:0]                   room;
    logic [P:0]                   rs12;
    logic [P-1:0]                 nk;
    logic [crcp_pkg::CHAR_W-1:0]  ch;
    logic                         do_end;
    logic [W:0]                   ns;
    logic [W+1:0]                 ns_end;

    pos_nxt     = pos_r;
    vt_nxt      = vt_r;
    rs_nxt      = rs_r;
    nxt_off_nxt = nxt_off_r;
    act_nxt     = act_r;
    nlen_nxt    = nlen_r;
    lo_nxt      = lo_r;
    nuls_nxt    = nuls_r;
    nne_nxt     = nne_r;
    ph_nxt      = ph_r;
    batch       = '0;
    do_end      = 1'b0;
    koff        = '0;
    k           = '0;
    sh          = '0;
    name_start  = '0;
    room        = '0;
    nk          = '0;
    ch          = '0;
    ns          = '0;
    ns_end      = '0;

    // first byte of a batch
    if (pos_r == '0) begin
      vt_nxt   = (iblen_r > BUF_MAX) ? BUF_MAX : iblen_r;
      rs_nxt   = '0;
      nuls_nxt = '0;
      nne_nxt  = 1'b0;
      ph_nxt   = PH_HEADER;
      if (vt_nxt < P'(crcp_pkg::HDR_BYTES)) begin
        batch  = push(batch, crcp_pkg::KIND_MALFORMED, '0, '0, '0);
        ph_nxt = PH_DONE;
      end
    end

    if (ph_nxt == PH_SKIP && pos_r == rs_nxt) ph_nxt = PH_HEADER;

    koff = pos_r - rs_nxt;
    rs12 = {1'b0, rs_nxt} + (P+1)'(crcp_pkg::HDR_BYTES);

    if (ph_nxt == PH_HEADER && pos_r >= rs_nxt && koff < P'(crcp_pkg::HDR_BYTES)) begin
      // header byte capture
      k  = koff[3:0];
      sh = {k[1:0], 3'b000};
      if (k == 4'd0) begin
        nxt_off_nxt = '0;
        act_nxt     = '0;
        nlen_nxt    = '0;
        nuls_nxt    = '0;
        nne_nxt     = 1'b0;
      end
      if (k < 4'd4)      nxt_off_nxt = nxt_off_nxt | (W'(ibyte_r) << sh);
      else if (k < 4'd8) act_nxt     = act_nxt | (W'(ibyte_r) << sh);
      else               nlen_nxt    = nlen_nxt | (W'(ibyte_r) << sh);
      if (k == 4'd11) begin
        name_start = rs12;
        room = ({1'b0, vt_nxt} >= name_start) ? ({1'b0, vt_nxt} - name_start) : '0;
        if (nlen_nxt > W'(room)) begin
          batch  = push(batch, crcp_pkg::KIND_MALFORMED, '0, '0, '0);
          ph_nxt = PH_DONE;
        end else if (nlen_nxt == '0) begin
          do_end = 1'b1;
        end else begin
          ph_nxt = PH_NAME;
        end
      end
    end else if (ph_nxt == PH_NAME && {1'b0, pos_r} >= rs12) begin
      // name byte: pair into a code unit
      nk = pos_r - rs12[P-1:0];
      if (!nk[0]) begin
        lo_nxt = ibyte_r;
      end else begin
        ch = {ibyte_r, lo_r};
        if (ch == '0) begin
          if (nuls_nxt != '1) nuls_nxt = nuls_nxt + 1'b1;
        end else begin
          batch    = push(batch, crcp_pkg::KIND_CHAR, ch, nuls_nxt, '0);
          nuls_nxt = '0;
          nne_nxt  = 1'b1;
        end
      end
      if ((W'(nk) + W'(1)) == nlen_nxt && nk != '1) do_end = 1'b1;
    end

    // record end and chain link check
    if (do_end) begin
      if (nne_nxt) batch = push(batch, crcp_pkg::KIND_REC_END, '0, '0, act_nxt);
      ns     = (W+1)'(rs_nxt) + (W+1)'(nxt_off_nxt);
      ns_end = (W+2)'(ns) + (W+2)'(crcp_pkg::HDR_BYTES);
      if (nxt_off_nxt == '0) begin
        batch  = push(batch, crcp_pkg::KIND_OK, '0, '0, '0);
        ph_nxt = PH_DONE;
      end else if ({1'b0, nxt_off_nxt} <
                   ((W+1)'(nlen_nxt) + (W+1)'(crcp_pkg::HDR_BYTES))) begin
        batch  = push(batch, crcp_pkg::KIND_MALFORMED, '0, '0, '0);
        ph_nxt = PH_DONE;
      end else if (ns_end > (W+2)'(vt_nxt)) begin
        batch  = push(batch, crcp_pkg::KIND_OK, '0, '0, '0);
        ph_nxt = PH_DONE;
      end else begin
        rs_nxt = ns[P-1:0];
        ph_nxt = PH_SKIP;
      end
    end

    if (pos_r != '1) pos_nxt = pos_r + 1'b1;

    // end of batch
    if (ilast_r) begin
      if (ph_nxt != PH_DONE) batch = push(batch, crcp_pkg::KIND_MALFORMED, '0, '0, '0);
      pos_nxt = '0;
      ph_nxt  = PH_HEADER;
    end
  end

  // input register and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r    <= 1'b0;
      pos_r     <= '0;
      vt_r      <= '0;
      rs_r      <= '0;
      nxt_off_r <= '0;
      act_r     <= '0;
      nlen_r    <= '0;
      lo_r      <= '0;
      nuls_r    <= '0;
      nne_r     <= 1'b0;
      ph_r      <= PH_HEADER;
    end else begin
      if (in_valid && in_ready) begin
        ivld_r  <= 1'b1;
        ibyte_r <= in_byte;
        iblen_r <= in_blen;
        ilast_r <= in_last;
      end else if (consume) begin
        ivld_r  <= 1'b0;
      end
      if (consume) begin
        pos_r     <= pos_nxt;
        vt_r      <= vt_nxt;
        rs_r      <= rs_nxt;
        nxt_off_r <= nxt_off_nxt;
        act_r     <= act_nxt;
        nlen_r    <= nlen_nxt;
        lo_r      <= lo_nxt;
        nuls_r    <= nuls_nxt;
        nne_r     <= nne_nxt;
        ph_r      <= ph_nxt;
      end
    end
  end

endmodule

// ----- rtl/crcp_outbuf.sv -----
module crcp_outbuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  crcp_pkg::batch_t              batch,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output crcp_pkg::result_t             out_res,
  output logic                          out_run_end
);

  crcp_pkg::result_t [crcp_pkg::MAX_RES-1:0] res_r;
  logic [crcp_pkg::CNT_W-1:0]                cnt_r;
  logic [crcp_pkg::CNT_W-1:0]                idx_r;
  logic                                      pop;
  logic                                      at_end;

  assign out_valid   = idx_r < cnt_r;
  assign at_end      = (idx_r + 1'b1) == cnt_r;
  assign pop         = out_valid & out_ready;
  assign free        = ~out_valid | (pop & at_end);
  assign out_res     = res_r[idx_r];
  assign out_run_end = at_end;

  // result holding register, drained one beat at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      res_r <= batch.res;
      cnt_r <= batch.cnt;
      idx_r <= '0;
    end else if (pop) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

// ----- rtl/change_record_chain_parser.sv -----
// channel  | dir | beat payload
// in_ch    | in  | byte_value[7:0], batch_length[16:0], last
// out_ch   | out | kind[1:0], character[15:0], nuls_before[14:0], action[31:0], run_end
//
// one byte per cycle when each byte causes at most one result and out_ch is ready;
// a byte causing more than one result stalls the input until its last result is taken (result drain, one per beat)
// first result passes the input register, the combinational parse step and the result register
// rst_n is synchronous; it clears the batch position and returns to header parsing
// out_ch stall backs up through the result register into the input register
module change_record_chain_parser #(
  parameter int BUFFER_BYTES = crcp_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  crcp_in_if.sink     in_ch,
  crcp_out_if.source  out_ch
);

  logic              buf_free;
  logic              buf_load;
  crcp_pkg::batch_t  buf_batch;
  crcp_pkg::result_t out_res;

  crcp_parse #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.byte_value),
    .in_blen   (in_ch.batch_length),
    .in_last   (in_ch.last),
    .buf_free  (buf_free),
    .buf_load  (buf_load),
    .buf_batch (buf_batch)
  );

  crcp_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (buf_load),
    .batch       (buf_batch),
    .free        (buf_free),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_res     (out_res),
    .out_run_end (out_ch.run_end)
  );

  // result fields onto the channel
  assign out_ch.kind        = out_res.kind;
  assign out_ch.character   = out_res.character;
  assign out_ch.nuls_before = out_res.nuls_before;
  assign out_ch.action      = out_res.action;

endmodule

// ----- sim/tb_change_record_chain_parser.sv -----
module tb_change_record_chain_parser;

  localparam int HDR         = crcp_pkg::HDR_BYTES;
  localparam int BUF         = crcp_pkg::BUFFER_BYTES_DEF;
  localparam int RAND_BYTES  = 40;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_SKIP, PH_DONE} parse_phase_t;
  typedef enum logic [1:0] {FILL_FLAT, FILL_LEAD_NUL, FILL_TRAIL_NUL} name_fill_t;

  // one result beat as it leaves the block
  typedef struct packed {
    crcp_pkg::result_t res;
    logic              run_end;
  } chain_beat_t;

  // one directed batch: a record at offset 0, and a short second record at
  // next_ofs when that is nonzero; n_exp > 0 means the results are typed in
  typedef struct packed {
    logic [16:0]     blen;
    int              nbytes;
    logic [31:0]     next_ofs;
    logic [31:0]     action;
    logic [31:0]     name_len;
    logic [15:0]     unit;
    name_fill_t      fill;
    int              n_exp;
    crcp_pkg::kind_t status;
  } dir_row_t;

  logic clk;
  logic rst_n;

  crcp_in_if  in_ch();
  crcp_out_if out_ch();

  change_record_chain_parser dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  chain_beat_t  pending_beats[$];
  logic [7:0]   chain_bytes[$];
  int           errors = 0;
  int           stuck_cycles = 0;
  int           stall_left;
  bit           steady_run;
  bit           typed_row;

  // parser image
  logic [16:0]       m_pos;
  logic [31:0]       m_total;
  logic [31:0]       m_rec_start;
  logic [31:0]       m_next;
  logic [31:0]       m_action;
  logic [31:0]       m_nlen;
  logic [7:0]        m_low;
  logic [14:0]       m_nuls;
  logic              m_nonempty;
  parse_phase_t      m_phase;
  crcp_pkg::result_t step_res[crcp_pkg::MAX_RES];
  int                step_n;

  dir_row_t dir_rows [0:18] = '{
    // short batches, header-only records, overruns, early last
    '{17'd0,       1,  32'd0,          32'd0,          32'd0,          16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_MALFORMED},
    '{17'd11,      4,  32'd0,          32'd0,          32'd0,          16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_MALFORMED},
    '{17'd12,      12, 32'd0,          32'd0,          32'd0,          16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_OK},
    '{17'd12,      12, 32'd11,         32'd1,          32'd0,          16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_MALFORMED},
    '{17'd20,      12, 32'd0,          32'd7,          32'd10,         16'h1234,
      FILL_FLAT, 1, crcp_pkg::KIND_MALFORMED},
    '{17'd14,      14, 32'd0,          32'hFFFF_FFFF,  32'd2,          16'hFFFF,
      FILL_FLAT, 3, crcp_pkg::KIND_OK},
    '{17'd200,     5,  32'd0,          32'd0,          32'd0,          16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_MALFORMED},
    '{17'h1FFFF,   12, 32'hFFFF_FFFF,  32'd0,          32'd0,          16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_OK},
    '{17'd100,     12, 32'd0,          32'd0,          32'hFFFF_FFFF,  16'h0000,
      FILL_FLAT, 1, crcp_pkg::KIND_MALFORMED},
    '{17'd40,      14, 32'd0,          32'h8000_0001,  32'd2,          16'h8000,
      FILL_FLAT, 3, crcp_pkg::KIND_OK},
    // chains, links back into the name, clamps, odd lengths and NUL runs
    '{17'h1FFFF,   30, 32'd16,         32'd1,          32'd4,          16'h0001,
      FILL_LEAD_NUL, 0, crcp_pkg::KIND_OK},
    '{17'd30,      18, 32'd14,         32'd2,          32'd4,          16'h00FF,
      FILL_FLAT, 0, crcp_pkg::KIND_OK},
    '{17'd35,      16, 32'd30,         32'd4,          32'd2,          16'h7FFF,
      FILL_FLAT, 0, crcp_pkg::KIND_OK},
    '{17'd17,      17, 32'd0,          32'd5,          32'd5,          16'h1234,
      FILL_FLAT, 0, crcp_pkg::KIND_OK},
    '{17'd20,      20, 32'd0,          32'd6,          32'd8,          16'h0000,
      FILL_FLAT, 0, crcp_pkg::KIND_OK},
    '{17'd50,      15, 32'd0,          32'd8,          32'd8,          16'h5555,
      FILL_FLAT, 0, crcp_pkg::KIND_OK},
    '{17'd65536,   16, 32'd0,          32'd9,          32'd4,          16'hAAAA,
      FILL_TRAIL_NUL, 0, crcp_pkg::KIND_OK},
    '{17'd65537,   16, 32'd12,         32'd10,         32'd0,          16'h0000,
      FILL_FLAT, 0, crcp_pkg::KIND_OK},
    '{17'd13,      13, 32'd0,          32'd11,         32'd2,          16'h0001,
      FILL_FLAT, 0, crcp_pkg::KIND_OK}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_unit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r == 3) return 16'($urandom_range(1, 255));
    if (r == 4) return 16'($urandom_range(1, 255) << 8);
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic chain_beat_t make_beat(input crcp_pkg::kind_t k, input logic [15:0] ch,
                                            input logic [31:0] act, input logic e);
    chain_beat_t bt;
    bt.res.kind        = k;
    bt.res.character   = ch;
    bt.res.nuls_before = '0;
    bt.res.action      = act;
    bt.run_end         = e;
    return bt;
  endfunction

  // expected beat to the tail of the queue
  task automatic queue_beat(input chain_beat_t bt);
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  // stimulus byte to the tail of the buffer image
  task automatic add_byte(input logic [7:0] b);
    chain_bytes.insert(chain_bytes.size(), b);
  endtask

  // ---------------------------------------------------------------------------
  // parser image: one byte in, the results it causes queued
  // ---------------------------------------------------------------------------

  task automatic push_result(input crcp_pkg::kind_t k, input logic [15:0] ch,
                             input logic [14:0] nuls, input logic [31:0] act);
    if (step_n < crcp_pkg::MAX_RES) begin
      step_res[step_n].kind        = k;
      step_res[step_n].character   = ch;
      step_res[step_n].nuls_before = nuls;
      step_res[step_n].action      = act;
      step_n++;
    end
  endtask

  task automatic close_chain(input crcp_pkg::kind_t k);
    push_result(k, '0, '0, '0);
    m_phase = PH_DONE;
  endtask

  // record finished: action if the name had a character, then follow the link
  task automatic close_record();
    longint unsigned lim;
    longint unsigned nxt_start;
    lim = m_nlen;
    lim = lim + HDR;
    nxt_start = m_rec_start;
    nxt_start = nxt_start + m_next;
    if (m_nonempty) push_result(crcp_pkg::KIND_REC_END, '0, '0, m_action);
    if (m_next == 0) begin
      close_chain(crcp_pkg::KIND_OK);
    end else if (m_next < lim) begin
      close_chain(crcp_pkg::KIND_MALFORMED);
    end else if (nxt_start + HDR > m_total) begin
      close_chain(crcp_pkg::KIND_OK);
    end else begin
      m_rec_start = nxt_start[31:0];
      m_phase     = PH_SKIP;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic [16:0] blen, input logic lst);
    logic [31:0]     pos;
    logic [31:0]     k;
    logic [15:0]     ch;
    longint unsigned name_start;
    longint unsigned room;
    longint unsigned k_next;
    chain_beat_t     bt;
    pos    = {15'd0, m_pos};
    step_n = 0;

    // first byte of a batch samples the length
    if (pos == 0) begin
      m_total     = (blen > 17'(BUF)) ? 32'(BUF) : {15'd0, blen};
      m_rec_start = '0;
      m_nuls      = '0;
      m_nonempty  = 1'b0;
      m_phase     = PH_HEADER;
      if (m_total < HDR) close_chain(crcp_pkg::KIND_MALFORMED);
    end

    if (m_phase == PH_SKIP && pos == m_rec_start) m_phase = PH_HEADER;

    if (m_phase == PH_HEADER && pos >= m_rec_start && pos - m_rec_start < HDR) begin
      // header words, little endian
      k = pos - m_rec_start;
      if (k == 0) begin
        m_next     = '0;
        m_action   = '0;
        m_nlen     = '0;
        m_nuls     = '0;
        m_nonempty = 1'b0;
      end
      if (k < 4)      m_next[8*k[1:0] +: 8]   = b;
      else if (k < 8) m_action[8*k[1:0] +: 8] = b;
      else            m_nlen[8*k[1:0] +: 8]   = b;
      if (k == HDR - 1) begin
        name_start = m_rec_start;
        name_start = name_start + HDR;
        room = (m_total >= name_start) ? m_total - name_start : 0;
        if (m_nlen > room)   close_chain(crcp_pkg::KIND_MALFORMED);
        else if (m_nlen == 0) close_record();
        else                  m_phase = PH_NAME;
      end
    end else if (m_phase == PH_NAME && pos >= m_rec_start + HDR) begin
      // name code units, NULs held until a character follows
      k = pos - (m_rec_start + HDR);
      if (!k[0]) begin
        m_low = b;
      end else begin
        ch = {b, m_low};
        if (ch == 0) begin
          if (m_nuls != 15'h7FFF) m_nuls++;
        end else begin
          push_result(crcp_pkg::KIND_CHAR, ch, m_nuls, '0);
          m_nuls     = '0;
          m_nonempty = 1'b1;
        end
      end
      k_next = k;
      k_next = k_next + 1;
      if (k_next == m_nlen) close_record();
    end

    if (m_pos != '1) m_pos++;

    if (lst) begin
      if (m_phase != PH_DONE) close_chain(crcp_pkg::KIND_MALFORMED);
      m_pos   = '0;
      m_phase = PH_HEADER;
    end

    if (!typed_row) begin
      for (int i = 0; i < step_n; i++) begin
        bt.res     = step_res[i];
        bt.run_end = (i == step_n - 1);
        queue_beat(bt);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endtask

  // byte p of a directed batch; the header is even-sized so name byte parity is p parity
  function automatic logic [7:0] dir_byte(input dir_row_t r, input int p);
    logic [95:0]     hdr;
    logic [95:0]     hdr2;
    logic [15:0]     u;
    longint unsigned nl;
    longint unsigned nx;
    longint unsigned q;
    longint unsigned ui;
    int              off;
    hdr  = {r.name_len, r.action, r.next_ofs};
    hdr2 = {32'd2, ~r.action, 32'd0};
    nl   = r.name_len;
    nx   = r.next_ofs;
    q    = 64'(p);
    if (q < HDR) return hdr[8*p +: 8];
    if (q < HDR + nl) begin
      ui = (q - HDR) / 2;
      case (r.fill)
        FILL_LEAD_NUL:  u = (ui == nl / 2 - 1) ? r.unit : '0;
        FILL_TRAIL_NUL: u = (ui == 0) ? r.unit : '0;
        default:        u = r.unit;
      endcase
      return q[0] ? u[15:8] : u[7:0];
    end
    if (nx != 0 && q >= nx && q < nx + HDR) begin
      off = int'(q - nx);
      return hdr2[8*off +: 8];
    end
    if (nx != 0 && q >= nx + HDR && q < nx + HDR + 2) return q[0] ? 8'h00 : 8'h41;
    return 8'hA5;
  endfunction

  // mostly well-formed chains of one to three records, some broken, some noise
  task automatic build_random_chain(output logic [16:0] blen, output int nbytes);
    int          nrec;
    int          nlen;
    int          gap;
    int          sz;
    int          pick;
    logic [31:0] nxt;
    logic [15:0] u;
    chain_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
      blen   = 17'($urandom_range(0, 40));
      nbytes = chain_bytes.size();
      return;
    end
    nrec = $urandom_range(1, 3);
    for (int r = 0; r < nrec; r++) begin
      nlen = 2 * $urandom_range(0, 6) + ($urandom_range(0, 4) == 0);
      gap  = $urandom_range(0, 5);
      if (r == nrec - 1) nxt = ($urandom_range(0, 9) == 0) ? $urandom : 32'd0;
      else               nxt = HDR + nlen + gap;
      // link pointing back into the header or the name
      if ($urandom_range(0, 9) == 0) nxt = $urandom_range(1, HDR + nlen - 1);
      put_word(nxt);
      put_word($urandom);
      put_word(nlen);
      for (int i = 0; i < nlen; i += 2) begin
        u = pick_unit();
        add_byte(u[7:0]);
        if (i + 1 < nlen) add_byte(u[15:8]);
      end
      if (r != nrec - 1) repeat (gap) add_byte(8'($urandom_range(0, 255)));
    end
    sz   = chain_bytes.size();
    pick = $urandom_range(0, 99);
    if (pick < 75)      blen = 17'(sz);
    else if (pick < 87) blen = 17'($urandom_range(0, sz));
    else                blen = 17'($urandom_range(sz, 17'h1FFFF));
    pick = $urandom_range(0, 99);
    if (pick < 80)      nbytes = sz + $urandom_range(0, 4);
    else if (pick < 92) nbytes = $urandom_range(1, sz);
    else                nbytes = sz + $urandom_range(5, 20);
  endtask

  // one input beat, held until taken; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic [16:0] blen, input logic lst);
    int gap;
    gap = steady_run ? 0 : pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.byte_value   <= b;
    in_ch.batch_length <= blen;
    in_ch.last         <= lst;
    do @(posedge clk); while (!in_ch.ready);
    parse_byte(b, blen, lst);
    @(negedge clk);
  endtask

  // bytes past the built buffer are random; length only matters on the first
  task automatic send_batch(input logic [16:0] blen, input int nbytes);
    logic [7:0]  b;
    logic [16:0] bl;
    for (int i = 0; i < nbytes; i++) begin
      b  = (i < chain_bytes.size()) ? chain_bytes[i] : 8'($urandom_range(0, 255));
      bl = (i == 0) ? blen : 17'($urandom_range(0, 17'h1FFFF));
      send_byte(b, bl, i == nbytes - 1);
    end
  endtask

  // main sequence
  initial begin
    logic [16:0] blen;
    int          nbytes;
    int          random_bytes;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.byte_value   = '0;
    in_ch.batch_length = '0;
    in_ch.last         = 1'b0;
    steady_run         = 1'b0;
    typed_row          = 1'b0;
    m_pos              = '0;
    m_total            = '0;
    m_rec_start        = '0;
    m_next             = '0;
    m_action           = '0;
    m_nlen             = '0;
    m_low              = '0;
    m_nuls             = '0;
    m_nonempty         = 1'b0;
    m_phase            = PH_HEADER;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed batches
    foreach (dir_rows[r]) begin
      chain_bytes.delete();
      for (int p = 0; p < dir_rows[r].nbytes; p++) begin
        add_byte(dir_byte(dir_rows[r], p));
      end
      typed_row = (dir_rows[r].n_exp != 0);
      if (dir_rows[r].n_exp == 3) begin
        queue_beat(make_beat(crcp_pkg::KIND_CHAR, dir_rows[r].unit, '0, 1'b0));
        queue_beat(make_beat(crcp_pkg::KIND_REC_END, '0, dir_rows[r].action, 1'b0));
      end
      if (typed_row) queue_beat(make_beat(dir_rows[r].status, '0, '0, 1'b1));
      steady_run = ($urandom_range(0, 3) == 0);
      send_batch(dir_rows[r].blen, dir_rows[r].nbytes);
    end
    typed_row = 1'b0;

    // random chains
    random_bytes = 0;
    while (random_bytes < RAND_BYTES) begin
      build_random_chain(blen, nbytes);
      steady_run = ($urandom_range(0, 5) == 0);
      send_batch(blen, nbytes);
      random_bytes += nbytes;
    end
    steady_run = 1'b0;

    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("PASS change_record_chain_parser");
    end else begin
      $display("FAIL change_record_chain_parser");
    end
    $finish;
  end

  // result side: random stalls
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = steady_run ? 0 : pick_idle();
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // result check against the oldest pending beat
  always @(posedge clk) begin
    chain_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat kind %0d char %h nuls %0d action %h end %b", $time,
                 out_ch.kind, out_ch.character, out_ch.nuls_before, out_ch.action,
                 out_ch.run_end);
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.kind !== want.res.kind || out_ch.character !== want.res.character ||
            out_ch.nuls_before !== want.res.nuls_before ||
            out_ch.action !== want.res.action || out_ch.run_end !== want.run_end) begin
          errors++;
          $display("%0t: beat mismatch exp kind %0d char %h nuls %0d action %h end %b",
                   $time, want.res.kind, want.res.character, want.res.nuls_before,
                   want.res.action, want.run_end);
          $display("%0t:                got kind %0d char %h nuls %0d action %h end %b",
                   $time, out_ch.kind, out_ch.character, out_ch.nuls_before,
                   out_ch.action, out_ch.run_end);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL change_record_chain_parser");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/crcp_pkg.sv
rtl/crcp_in_if.sv
rtl/crcp_out_if.sv
rtl/crcp_parse.sv
rtl/crcp_outbuf.sv
rtl/change_record_chain_parser.sv
sim/tb_change_record_chain_parser.sv
